FILE: hdl/assert_macros.svh
// Assertion helpers for the checker module of the emboss filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/edf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CHAN_W        = 8;
    localparam int CFG_WIDTH_W   = 12;
    localparam int ROW_W         = 16;
    localparam int OUT_COL_W     = 11;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_WIDTH_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [ROW_W-1:0]       IMAGE_HEIGHT_RST = 16'd480;
    localparam logic [ROW_W-1:0]       MIN_HEIGHT       = 16'd3;
    localparam logic [9:0]             EMBOSS_BIAS      = 10'd128;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // cur - prev + 128, clamped to 0..255.
    function automatic logic [CHAN_W-1:0] emboss_chan(
        input logic [CHAN_W-1:0] cur,
        input logic [CHAN_W-1:0] prev
    );
        logic [9:0]        diff;
        logic [CHAN_W-1:0] res;
        diff = 10'(cur) - 10'(prev) + EMBOSS_BIAS;
        if (diff[9])
        begin
            res = '0;
        end
        else if (diff[8])
        begin
            res = '1;
        end
        else
        begin
            res = diff[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/edf_line_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

// One row of pixels. A write returns the old contents of the same entry
// through a read register, in the next cycle.
module edf_line_buffer
    import edf_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire pixel_t                   wdata,
    output pixel_t                        rdata
);

    pixel_t mem [DEPTH];
    pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/emboss_diagonal_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Diagonal emboss filter for a raster stream of 8-bit BGR pixels. Each
// pixel transfer on the input channel carries one pixel in raster order;
// frame_start marks the first pixel of a frame and forces its position to
// row 0, column 0. For every interior pixel (y,x) each channel of the
// result is pixel(y+1,x+1) - pixel(y,x-1) + 128, clamped to 0..255, and the
// result leaves with out_column = x and out_row = y through stage 1 and the
// output register. Pixels on the image border produce no output transfer.
// The block takes one pixel per clock unless the output stalls: the input
// side feeds a single-port line buffer (read-old-data, registered read)
// and a short subtract-and-clamp stage, and an output register lets a new
// pixel enter while a finished result waits for out_ready. The image
// size comes from two configuration registers written through the cfg
// channel, which is always ready: index 0 is image_width (pixels per row,
// clamped to 3..MAX_WIDTH, reset 640) and index 1 is image_height (rows per
// frame, at least 3, reset 480); other indexes are ignored. Write them only
// while no pixel is in flight. The line buffer is not cleared after reset;
// no clearing pass is needed because every entry is written on the first
// row before it is used for a result.
module emboss_diagonal_filter_core
    import edf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   frame_start,
    input  wire logic [CHAN_W-1:0]      blue_in,
    input  wire logic [CHAN_W-1:0]      green_in,
    input  wire logic [CHAN_W-1:0]      red_in,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CHAN_W-1:0]           blue_out,
    output logic [CHAN_W-1:0]           green_out,
    output logic [CHAN_W-1:0]           red_out,
    output logic [OUT_COL_W-1:0]        out_column,
    output logic [ROW_W-1:0]            out_row
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    // Wide enough for both the width register and MAX_WIDTH itself.
    localparam int EW_W   = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
    localparam int OCX_W  = (COL_W > OUT_COL_W) ? COL_W : OUT_COL_W;

    // Configuration registers.
    logic [CFG_WIDTH_W-1:0] image_width_reg;
    logic [ROW_W-1:0]       image_height_reg;

    // Raster position of the next pixel.
    logic [COL_W-1:0]       col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]       row_cnt_reg, row_cnt_next;

    // Stage 1: the accepted pixel and its position; the line buffer read
    // data for the same pixel arrives alongside it.
    logic                   s1_valid_reg;
    pixel_t                 s1_pix_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [ROW_W-1:0]       s1_row_reg;

    // The previous row's pixels one and two columns back.
    pixel_t                 delay_a_reg;
    pixel_t                 delay_b_reg;

    // Output register.
    logic                   out_valid_reg;
    pixel_t                 out_pix_reg;
    logic [OUT_COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]       out_row_reg;

    logic                   in_xfer;
    logic                   out_free;
    logic                   s1_advance;
    logic                   s1_has_result;
    logic [EW_W-1:0]        width_ext;
    logic [EW_W-1:0]        eff_width;
    logic [COL_W-1:0]       last_col;
    logic [ROW_W-1:0]       last_row;
    logic [COL_W-1:0]       col_cur;
    logic [ROW_W-1:0]       row_cur;
    pixel_t                 in_pix;
    pixel_t                 old_pix;
    pixel_t                 emb_pix;
    logic [OCX_W-1:0]       col_minus_one;

    // ------------------------------------------------------------------
    // Configuration port: always ready, unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective last column and last row after saturation.
    always_comb
    begin
        width_ext = EW_W'(image_width_reg);
        if (width_ext < EW_W'(3))
        begin
            eff_width = EW_W'(3);
        end
        else if (width_ext > EW_W'(MAX_WIDTH))
        begin
            eff_width = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
        last_col = COL_W'(eff_width - EW_W'(1));
        last_row = (image_height_reg < MIN_HEIGHT) ? (MIN_HEIGHT - 16'd1)
                                                   : (image_height_reg - 16'd1);
    end

    // ------------------------------------------------------------------
    // Handshake. The whole pipe moves whenever stage 1 can drain into the
    // output register, so a pixel enters every cycle unless a result is
    // stuck at the output.
    // ------------------------------------------------------------------
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Position counters. A frame-start pixel restarts at the origin; a
    // column at or past the last one closes the row, and a row at or past
    // the last one closes the frame.
    // ------------------------------------------------------------------
    assign in_pix = '{red: red_in, green: green_in, blue: blue_in};

    always_comb
    begin
        col_cur      = frame_start ? '0 : col_cnt_reg;
        row_cur      = frame_start ? '0 : row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_xfer)
        begin
            if (col_cur >= last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row_cur >= last_row) ? '0 : row_cur + 16'd1;
            end
            else
            begin
                col_cnt_next = col_cur + COL_W'(1);
                row_cnt_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: the incoming pixel replaces the previous row's pixel at
    // the same column, and that old pixel comes back in stage 1.
    // ------------------------------------------------------------------
    edf_line_buffer #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk   (clk),
        .en    (in_xfer),
        .addr  (col_cur),
        .wdata (in_pix),
        .rdata (old_pix)
    );

    // ------------------------------------------------------------------
    // Stage 1 register and the two-pixel delay on the previous row. The
    // delay shifts when a pixel leaves stage 1, so the pixel in stage 1
    // always sees the old pixel read two transfers before it.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            delay_a_reg  <= '0;
            delay_b_reg  <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                delay_a_reg <= old_pix;
                delay_b_reg <= delay_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pix_reg <= in_pix;
            s1_col_reg <= col_cur;
            s1_row_reg <= row_cur;
        end
    end

    // ------------------------------------------------------------------
    // Emboss arithmetic. A result exists once two rows and two columns of
    // the frame have been seen; it belongs to the pixel one row up and one
    // column left of the current one.
    // ------------------------------------------------------------------
    assign s1_has_result = (s1_row_reg >= 16'd2) && (s1_col_reg >= COL_W'(2));
    assign col_minus_one = OCX_W'(s1_col_reg) - OCX_W'(1);

    always_comb
    begin
        emb_pix.blue  = emboss_chan(s1_pix_reg.blue,  delay_b_reg.blue);
        emb_pix.green = emboss_chan(s1_pix_reg.green, delay_b_reg.green);
        emb_pix.red   = emboss_chan(s1_pix_reg.red,   delay_b_reg.red);
    end

    // ------------------------------------------------------------------
    // Output register. Pixels without a result pass through stage 1 and
    // leave nothing behind.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && s1_has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_has_result)
        begin
            out_pix_reg <= emb_pix;
            out_col_reg <= col_minus_one[OUT_COL_W-1:0];
            out_row_reg <= s1_row_reg - 16'd1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign blue_out   = out_pix_reg.blue;
    assign green_out  = out_pix_reg.green;
    assign red_out    = out_pix_reg.red;
    assign out_column = out_col_reg;
    assign out_row    = out_row_reg;

endmodule

`default_nettype wire

FILE: hdl/edf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Checks on the top level's ports.
module edf_checker
    import edf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [CHAN_W-1:0]    blue_out,
    input wire logic [CHAN_W-1:0]    green_out,
    input wire logic [CHAN_W-1:0]    red_out,
    input wire logic [OUT_COL_W-1:0] out_column,
    input wire logic [ROW_W-1:0]     out_row
);

    // A waiting result keeps its payload until it is taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(blue_out) && $stable(green_out) && $stable(red_out) && $stable(out_column) && $stable(out_row))

    // With the output register empty the input side must never stall.
    `ASSERT_SAME(a_in_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // Pixels on the top row and the left column never produce a result.
    `ASSERT_SAME(a_no_border_result, clk, rst_n, out_valid, (out_row != '0) && (out_column != '0))

    // The configuration port never back-pressures.
    `ASSERT_SAME(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind emboss_diagonal_filter_core edf_checker u_edf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .blue_out   (blue_out),
    .green_out  (green_out),
    .red_out    (red_out),
    .out_column (out_column),
    .out_row    (out_row)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the diagonal emboss filter core. A queue-fed driver
// offers pixel transfers, a monitor on the input side runs a line-buffer model
// of the filter for every accepted pixel, and a monitor on the output side
// compares each result transfer with the oldest predicted result.
module tb;
    import edf_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 10;
    // A pixel leaves the block through stage 1 and the output register, so the
    // settle wait after the last result means nothing is left inside.
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PIXELS = 1300;
    localparam int EXTREME_PIXELS = 150;
    localparam int FRAME_CAP     = 400;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int RELIEF_BIAS   = 128;
    localparam int CHAN_TOP      = 255;

    typedef struct packed {
        logic   mark;
        pixel_t px;
    } raster_item_t;

    typedef struct packed {
        pixel_t                 px;
        logic [OUT_COL_W-1:0]   column;
        logic [ROW_W-1:0]       row;
    } relief_t;

    // Every input of the block holds a known value from time zero.
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index   = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic                   frame_start = 1'b0;
    logic [CHAN_W-1:0]      blue_in     = '0;
    logic [CHAN_W-1:0]      green_in    = '0;
    logic [CHAN_W-1:0]      red_in      = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [CHAN_W-1:0]      blue_out;
    logic [CHAN_W-1:0]      green_out;
    logic [CHAN_W-1:0]      red_out;
    logic [OUT_COL_W-1:0]   out_column;
    logic [ROW_W-1:0]       out_row;

    // Idle percentages of both sides; the stimulus switches them per stage.
    int send_idle_pct = 19;
    int recv_idle_pct = 81;

    // Long receiver stalls are requested by the stimulus and served by the
    // receiver process, which counts the stalled cycles itself.
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    int pixels_queued = 0;
    int pixels_taken  = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int settings      = 0;

    raster_item_t pixel_q[$];
    relief_t      relief_due[$];

    // Filter model state: the previous row, the two-deep tap of values read
    // back from it, the raster position and the size registers.
    pixel_t                 line_buf [MAX_WIDTH_DEF] = '{default: '0};
    pixel_t                 tap_near = '0;
    pixel_t                 tap_far  = '0;
    logic [OUT_COL_W-1:0]   col_pos  = '0;
    logic [ROW_W-1:0]       row_pos  = '0;
    logic [CFG_WIDTH_W-1:0] width_reg  = IMAGE_WIDTH_RST;
    logic [ROW_W-1:0]       height_reg = IMAGE_HEIGHT_RST;
    // Line buffer entries below this column have been written at least once.
    int                     cols_written = 0;

    emboss_diagonal_filter_core uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_start(frame_start),
        .blue_in    (blue_in),
        .green_in   (green_in),
        .red_in     (red_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .blue_out   (blue_out),
        .green_out  (green_out),
        .red_out    (red_out),
        .out_column (out_column),
        .out_row    (out_row)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Effective row length: the register saturated to 3..2048.
    function automatic int eff_cols(int raw);
        if (raw < 3)
        begin
            return 3;
        end
        return (raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : raw;
    endfunction

    // Effective frame height: the register raised to at least 3.
    function automatic int eff_rows(int raw);
        return (raw < 3) ? 3 : raw;
    endfunction

    function automatic int lesser(int a, int b);
        return (a < b) ? a : b;
    endfunction

    // One channel of the emboss: current minus the old diagonal neighbor,
    // biased to mid gray and clamped to the 8-bit range.
    function automatic logic [CHAN_W-1:0] relief_level(logic [CHAN_W-1:0] cur,
                                                       logic [CHAN_W-1:0] prev);
        int v;
        v = int'(cur) - int'(prev) + RELIEF_BIAS;
        if (v < 0)
        begin
            v = 0;
        end
        else if (v > CHAN_TOP)
        begin
            v = CHAN_TOP;
        end
        return v[CHAN_W-1:0];
    endfunction

    // Advances the raster model by one accepted pixel. When the pixel sits at
    // (y+1,x+1) of an interior position, the result for (y,x) is queued.
    function automatic void emboss_advance(logic mark, pixel_t px);
        pixel_t  above;
        relief_t due;
        if (mark)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        if (row_pos >= 2 && col_pos >= 2)
        begin
            // tap_far holds the previous row's pixel two columns back.
            due.px.blue  = relief_level(px.blue, tap_far.blue);
            due.px.green = relief_level(px.green, tap_far.green);
            due.px.red   = relief_level(px.red, tap_far.red);
            due.column   = col_pos - 1'b1;
            due.row      = row_pos - 1'b1;
            relief_due.push_back(due);
        end
        above = line_buf[col_pos];
        line_buf[col_pos] = px;
        tap_far  = tap_near;
        tap_near = above;
        if (int'(col_pos) + 1 > cols_written)
        begin
            cols_written = int'(col_pos) + 1;
        end
        // A column at or past the last one ends the row, and likewise for
        // rows, so a shrunk size takes effect at once.
        if (int'(col_pos) >= eff_cols(int'(width_reg)) - 1)
        begin
            col_pos = '0;
            if (int'(row_pos) >= eff_rows(int'(height_reg)) - 1)
            begin
                row_pos = '0;
            end
            else
            begin
                row_pos = row_pos + 1'b1;
            end
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    function automatic void check_field(string name, logic [ROW_W-1:0] want,
                                        logic [ROW_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Register writes update the model copy of the size registers.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  = cfg_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input side: every pixel transfer runs through the model. The count is
    // bumped after the prediction so the drain check never sees an accepted
    // pixel whose result is not yet queued.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            emboss_advance(frame_start, {red_in, green_in, blue_in});
            pixels_taken++;
        end
    end

    // Output side: each result transfer is matched against the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin : relief_check
        relief_t due;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (relief_due.size() == 0)
            begin
                $error("result at row %0d column %0d with none predicted", out_row, out_column);
                mismatches++;
            end
            else
            begin
                due = relief_due.pop_front();
                check_field("blue_out", ROW_W'(due.px.blue), ROW_W'(blue_out));
                check_field("green_out", ROW_W'(due.px.green), ROW_W'(green_out));
                check_field("red_out", ROW_W'(due.px.red), ROW_W'(red_out));
                check_field("out_column", ROW_W'(due.column), ROW_W'(out_column));
                check_field("out_row", due.row, out_row);
            end
        end
    end

    // Pixel driver. A new payload is loaded only when the channel is empty or
    // the current transfer completes at this edge, so valid and payload stay
    // put while the block stalls.
    always @(posedge clk)
    begin : pixel_driver
        raster_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item = pixel_q.pop_front();
                in_valid    <= 1'b1;
                frame_start <= item.mark;
                blue_in     <= item.px.blue;
                green_in    <= item.px.green;
                red_in      <= item.px.red;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus long stalls on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Channel values lean toward 0 and 255 so the clamps are hit often.
    function automatic pixel_t random_pixel();
        pixel_t p;
        p = pixel_t'($urandom);
        if ($urandom_range(3) == 0)
        begin
            p.blue = $urandom_range(1) ? '1 : '0;
        end
        if ($urandom_range(3) == 0)
        begin
            p.green = $urandom_range(1) ? '1 : '0;
        end
        if ($urandom_range(3) == 0)
        begin
            p.red = $urandom_range(1) ? '1 : '0;
        end
        return p;
    endfunction

    function automatic pixel_t shade(int b, int g, int r);
        pixel_t p;
        p.blue  = 8'(b);
        p.green = 8'(g);
        p.red   = 8'(r);
        return p;
    endfunction

    function automatic void push_pixel(logic mark, pixel_t px);
        raster_item_t item;
        item.mark = mark;
        item.px   = px;
        pixel_q.push_back(item);
        pixels_queued++;
    endfunction

    // Queues random pixels; the first one carries the frame mark if asked,
    // and a noisy run scatters stray marks through the rest.
    function automatic void queue_pixels(int count, logic mark_first, logic noisy);
        for (int i = 0; i < count; i++)
        begin
            push_pixel((i == 0) ? mark_first : (noisy && $urandom_range(49) == 0),
                       random_pixel());
        end
    endfunction

    // Waits until every queued pixel went in and every predicted result came
    // out, then lets pixels that cause no result leave the pipeline.
    task automatic drain();
        @(posedge clk);
        while (pixels_taken != pixels_queued || relief_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Writes both size registers back to back; the unused top bits of the
    // width write carry random data, which the block must drop.
    task automatic program_size(int w, int h);
        write_reg(REG_IMAGE_WIDTH, {4'($urandom), 12'(w)});
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Mostly small images so results come often, with out-of-range and
    // maximal values now and then.
    task automatic pick_size(output int w, output int h);
        case ($urandom_range(19))
            0:       w = $urandom_range(0, 2);
            1:       w = $urandom_range(1) ? MAX_WIDTH_DEF : $urandom_range(2049, 4095);
            2, 3, 4: w = $urandom_range(13, 40);
            default: w = $urandom_range(3, 12);
        endcase
        case ($urandom_range(19))
            0:       h = $urandom_range(0, 2);
            1:       h = $urandom_range(1) ? 65535 : $urandom_range(1000, 65534);
            default: h = $urandom_range(3, 8);
        endcase
    endtask

    initial
    begin : stimulus
        int   w;
        int   h;
        int   area;
        int   done;
        int   random_start;
        logic must_mark;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Sizes below the legal range must act as a 3x3 image,
        // which gives exactly one interior pixel per frame.
        program_size(0, 1);
        // Blue falls far below zero, green far above 255, red stays at 128.
        queue_pixels(3, 1'b1, 1'b0);
        push_pixel(1'b0, shade(255, 0, 128));
        queue_pixels(4, 1'b0, 1'b0);
        push_pixel(1'b0, shade(0, 255, 128));
        // Second frame without a mark: the raster position wraps by itself.
        // Blue lands exactly on 0, green one above 255, red exactly on 255.
        queue_pixels(3, 1'b0, 1'b0);
        push_pixel(1'b0, shade(128, 127, 0));
        queue_pixels(4, 1'b0, 1'b0);
        push_pixel(1'b0, shade(0, 255, 127));
        // A frame cut short by a new frame mark at the start of its second row.
        queue_pixels(3, 1'b1, 1'b0);
        queue_pixels(4, 1'b1, 1'b0);
        drain();

        // The receiver stalls for a long stretch while a whole frame is
        // offered, so the block fills up and has to refuse input.
        program_size(10, 12);
        queue_pixels(120, 1'b1, 1'b0);
        holds_asked++;
        drain();

        // Random part in three idling stages. Each pass picks a size and
        // sends a few frames: mostly whole frames, some cut short, some
        // without a mark, some noisy, and some with a size change mid-frame.
        random_start = pixels_queued;
        while (pixels_queued - random_start < RANDOM_PIXELS)
        begin
            done = pixels_queued - random_start;
            if (done >= 2 * RANDOM_PIXELS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (done >= RANDOM_PIXELS / 3)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 19;
            end
            pick_size(w, h);
            drain();
            program_size(w, h);
            // A wider row may only continue the old frame when every column
            // it reaches already holds a pixel; otherwise start a new frame.
            must_mark = (eff_cols(w) > cols_written);
            repeat ($urandom_range(1, 3))
            begin
                area = lesser(eff_cols(w) * eff_rows(h), FRAME_CAP);
                case ($urandom_range(9))
                    0:
                    begin
                        queue_pixels($urandom_range(1, area), 1'b1, 1'b0);
                    end
                    1:
                    begin
                        queue_pixels(area, must_mark, 1'b0);
                    end
                    2:
                    begin
                        queue_pixels($urandom_range(1, FRAME_CAP / 2),
                                     must_mark | 1'($urandom_range(1)), 1'b1);
                    end
                    3:
                    begin
                        // Change the size in the middle of a frame, then go
                        // on without a mark.
                        queue_pixels($urandom_range(1, area), 1'b1, 1'b0);
                        drain();
                        w = $urandom_range(3, lesser(cols_written, 40));
                        h = $urandom_range(3, 8);
                        program_size(w, h);
                        area = lesser(eff_cols(w) * eff_rows(h), FRAME_CAP);
                        queue_pixels(area, 1'b0, 1'b0);
                    end
                    default:
                    begin
                        queue_pixels(area, 1'b1, 1'b0);
                    end
                endcase
                must_mark = 1'b0;
            end
        end

        // Size extremes without idling: the start of a frame with a width
        // register beyond the limit, then the tallest frame height with
        // narrow rows under a second long stall.
        drain();
        program_size(4095, 3);
        queue_pixels(EXTREME_PIXELS, 1'b1, 1'b0);
        drain();
        program_size(3, 65535);
        queue_pixels(EXTREME_PIXELS, 1'b1, 1'b0);
        holds_asked++;
        drain();

        $display("Covered %0d pixel transfers and %0d result transfers over %0d size settings.",
                 pixels_taken, results_seen, settings);
        $display("Included clamp limits, out-of-range sizes, frame wrap, mid-frame resizing.");
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a result that never arrives.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: emboss_diagonal_filter_core.f
+incdir+hdl
hdl/edf_pkg.sv
hdl/edf_line_buffer.sv
hdl/emboss_diagonal_filter_core.sv
hdl/edf_checker.sv
dv/tb.sv
